// ===== hw/rtl/alsa_pkg.sv =====
// Package for the array linked slot allocator.
// Holds the transaction payload structs, field widths and request codes.
// No dependencies.
`default_nettype none

package alsa_pkg;

  localparam int unsigned VAL_W = 16;
  localparam int unsigned IDX_W = 7;
  localparam int unsigned CNT_W = 7;

  localparam logic REQ_ALLOC   = 1'b0;
  localparam logic REQ_RECYCLE = 1'b1;

  typedef struct packed {
    logic             req_type;
    logic [VAL_W-1:0] entry_value;
    logic [VAL_W-1:0] match_key;
  } req_t;

  typedef struct packed {
    logic             ok;
    logic [IDX_W-1:0] slot_index;
    logic [CNT_W-1:0] freed_count;
  } rsp_t;

endpackage

`default_nettype wire

// ===== hw/rtl/array_linked_slot_allocator_core.sv =====
// Top level of the array linked slot allocator: free and busy lists in one link memory.
// Walks the lists with compare and increment logic under a small sequencer.
// Depends on alsa_pkg.
//
// Usage: a request transaction enters on in_valid_i/in_ready_o with payload in_i.
// An allocate pops the free list head, stores entry_value there, pushes the slot
// onto the busy list and returns its index; with an empty pool it returns ok=0.
// A recycle walks the busy list and moves every slot holding match_key onto the
// free list, returning the count. Every request gives exactly one response
// transaction on out_valid_o/out_ready_i with payload out_o.
// An allocate passes through ST_ALLOC and then ST_DONE, a failed one straight to ST_DONE.
// A recycle runs ST_REC_EVAL for each busy slot visited and ST_REC_FREE for each slot
// freed, visiting at most SLOTS slots. The walk follows one link per cycle through the
// registered read port of the link memory while no slot is freed; each freed slot
// costs an extra step on the single write port of that memory.
// One request is in flight at a time; in_ready_o is high while the sequencer is
// idle, even while a response waits in the output register.
// If the receiver stalls, the finished result waits until the output register is
// free. Reset empties the busy list and makes the whole pool free, with no
// clearing pass: untouched slots are tracked by a fill count.
`default_nettype none

module array_linked_slot_allocator_core #(
  parameter int unsigned SLOTS = 64
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output      logic           in_ready_o,
  input  wire alsa_pkg::req_t in_i,
  output      logic           out_valid_o,
  input  wire logic           out_ready_i,
  output      alsa_pkg::rsp_t out_o
);

  localparam int unsigned IW = $clog2(SLOTS + 1);
  localparam int unsigned AW = $clog2(SLOTS);
  localparam int unsigned XIW = (IW > alsa_pkg::IDX_W) ? IW : alsa_pkg::IDX_W;
  localparam int unsigned XCW = (IW > alsa_pkg::CNT_W) ? IW : alsa_pkg::CNT_W;
  localparam logic [IW-1:0] END = IW'(SLOTS);

  typedef enum logic [4:0] {
    ST_IDLE     = 5'b00001,
    ST_ALLOC    = 5'b00010,
    ST_REC_EVAL = 5'b00100,
    ST_REC_FREE = 5'b01000,
    ST_DONE     = 5'b10000
  } state_e;

  state_e state_q, state_d;

  logic [IW-1:0] cur_q, cur_d;
  logic [IW-1:0] prev_q, prev_d;
  logic [IW-1:0] nxt_q, nxt_d;
  logic [IW-1:0] steps_q, steps_d;
  logic [IW-1:0] freed_q, freed_d;
  logic [IW-1:0] free_head_q, free_head_d;
  logic [IW-1:0] busy_head_q, busy_head_d;
  logic [IW-1:0] fresh_q, fresh_d;
  logic [IW-1:0] res_idx_q, res_idx_d;
  logic          res_ok_q, res_ok_d;
  logic [alsa_pkg::VAL_W-1:0] key_q, key_d;
  logic [alsa_pkg::VAL_W-1:0] value_q, value_d;
  logic           out_valid_q, out_valid_d;
  alsa_pkg::rsp_t out_q, out_d;

  logic [IW-1:0] link_mem [SLOTS];
  logic [alsa_pkg::VAL_W-1:0] val_mem [SLOTS];
  logic [IW-1:0] link_rd_q;
  logic [alsa_pkg::VAL_W-1:0] val_rd_q;

  logic          rd_en;
  logic [IW-1:0] rd_addr;
  logic          link_we;
  logic [IW-1:0] link_waddr;
  logic [IW-1:0] link_wdata;
  logic          val_we;
  logic [IW-1:0] steps_inc;
  logic [XIW-1:0] idx_ext;
  logic [XCW-1:0] cnt_ext;

  assign steps_inc = steps_q + IW'(1);
  assign idx_ext   = XIW'(res_idx_q);
  assign cnt_ext   = XCW'(freed_q);

  always_ff @(posedge clk_i) begin
    if (link_we) begin
      link_mem[link_waddr[AW-1:0]] <= link_wdata;
    end
    if (rd_en) begin
      if (rd_addr >= fresh_q) begin
        link_rd_q <= rd_addr + IW'(1);
      end else begin
        link_rd_q <= link_mem[rd_addr[AW-1:0]];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (val_we) begin
      val_mem[free_head_q[AW-1:0]] <= value_q;
    end
    if (rd_en) begin
      val_rd_q <= val_mem[rd_addr[AW-1:0]];
    end
  end

  always_comb begin
    state_d     = state_q;
    cur_d       = cur_q;
    prev_d      = prev_q;
    nxt_d       = nxt_q;
    steps_d     = steps_q;
    freed_d     = freed_q;
    free_head_d = free_head_q;
    busy_head_d = busy_head_q;
    fresh_d     = fresh_q;
    res_idx_d   = res_idx_q;
    res_ok_d    = res_ok_q;
    key_d       = key_q;
    value_d     = value_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    rd_en       = 1'b0;
    rd_addr     = cur_q;
    link_we     = 1'b0;
    link_waddr  = cur_q;
    link_wdata  = free_head_q;
    val_we      = 1'b0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          key_d     = in_i.match_key;
          value_d   = in_i.entry_value;
          freed_d   = '0;
          res_idx_d = END;
          if (in_i.req_type == alsa_pkg::REQ_ALLOC) begin
            if (free_head_q >= END) begin
              res_ok_d = 1'b0;
              state_d  = ST_DONE;
            end else begin
              rd_en   = 1'b1;
              rd_addr = free_head_q;
              state_d = ST_ALLOC;
            end
          end else begin
            res_ok_d = 1'b1;
            if (busy_head_q >= END) begin
              state_d = ST_DONE;
            end else begin
              rd_en   = 1'b1;
              rd_addr = busy_head_q;
              cur_d   = busy_head_q;
              prev_d  = END;
              steps_d = '0;
              state_d = ST_REC_EVAL;
            end
          end
        end
      end
      ST_ALLOC: begin
        link_we     = 1'b1;
        link_waddr  = free_head_q;
        link_wdata  = busy_head_q;
        val_we      = 1'b1;
        free_head_d = link_rd_q;
        busy_head_d = free_head_q;
        if (free_head_q == fresh_q) begin
          fresh_d = fresh_q + IW'(1);
        end
        res_ok_d  = 1'b1;
        res_idx_d = free_head_q;
        state_d   = ST_DONE;
      end
      ST_REC_EVAL: begin
        steps_d = steps_inc;
        nxt_d   = link_rd_q;
        if (val_rd_q == key_q) begin
          if (prev_q >= END) begin
            busy_head_d = link_rd_q;
          end else begin
            link_we    = 1'b1;
            link_waddr = prev_q;
            link_wdata = link_rd_q;
          end
          state_d = ST_REC_FREE;
        end else begin
          prev_d = cur_q;
          if (link_rd_q < END && steps_inc < END) begin
            rd_en   = 1'b1;
            rd_addr = link_rd_q;
            cur_d   = link_rd_q;
          end else begin
            state_d = ST_DONE;
          end
        end
      end
      ST_REC_FREE: begin
        link_we     = 1'b1;
        link_waddr  = cur_q;
        link_wdata  = free_head_q;
        free_head_d = cur_q;
        freed_d     = freed_q + IW'(1);
        if (nxt_q < END && steps_q < END) begin
          rd_en   = 1'b1;
          rd_addr = nxt_q;
          cur_d   = nxt_q;
          state_d = ST_REC_EVAL;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d       = 1'b1;
          out_d.ok          = res_ok_q;
          out_d.slot_index  = idx_ext[alsa_pkg::IDX_W-1:0];
          out_d.freed_count = cnt_ext[alsa_pkg::CNT_W-1:0];
          state_d           = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      free_head_q <= '0;
      busy_head_q <= END;
      fresh_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      free_head_q <= free_head_d;
      busy_head_q <= busy_head_d;
      fresh_q     <= fresh_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q     <= cur_d;
    prev_q    <= prev_d;
    nxt_q     <= nxt_d;
    steps_q   <= steps_d;
    freed_q   <= freed_d;
    res_idx_q <= res_idx_d;
    res_ok_q  <= res_ok_d;
    key_q     <= key_d;
    value_q   <= value_d;
    out_q     <= out_d;
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni) fresh_q <= END)
    else $error("Fill count exceeds the pool size.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
      (free_head_q >= END) |-> (fresh_q == END))
    else $error("Free list is empty while untouched slots remain.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
      (state_q == ST_DONE && !res_ok_q) |-> (free_head_q >= END))
    else $error("Allocate failed although the free list is not empty.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
      (state_q == ST_REC_FREE) |=> (freed_q == $past(freed_q) + IW'(1)))
    else $error("Freed count did not advance on a freed slot.");

endmodule

`default_nettype wire
